>>> rtl/hbkd_pkg.sv
// Package for the HID boot-keyboard report differ.
// Holds the byte type, the slot constants and the scancode and ASCII lookups.
// No dependencies.
package hbkd_pkg;

    typedef logic [7:0] t_byte;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int INPUT_FIELDS  = 6;
    localparam int ROM_SPAN      = 32;

    localparam t_byte ASCII_FIRST = 8'h04;
    localparam t_byte ASCII_LAST  = 8'h1D;
    localparam t_byte ASCII_BASE  = 8'h61;

    localparam t_byte SCAN_ROM [ROM_SPAN] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h46, 8'h26, 8'h85,
        8'h65, 8'h45, 8'h25, 8'h84, 8'h64, 8'h44, 8'h24, 8'h83,
        8'h63, 8'h43, 8'h23, 8'h82, 8'h62, 8'h42, 8'h22, 8'h81,
        8'h61, 8'h41, 8'h21, 8'h80, 8'h60, 8'h40, 8'h00, 8'h00
    };

    function automatic t_byte f_scan(input t_byte u);
        t_byte res;
        res = 8'h00;
        if (u < 8'(ROM_SPAN)) begin
            res = SCAN_ROM[u[4:0]];
        end
        return res;
    endfunction

    function automatic t_byte f_ascii(input t_byte u);
        t_byte res;
        res = 8'h00;
        if (u >= ASCII_FIRST && u <= ASCII_LAST) begin
            res = ASCII_BASE + (u - ASCII_FIRST);
        end
        return res;
    endfunction

endpackage

>>> rtl/hbkd_diff.sv
// Key list comparator: flags released stored keys and newly pressed keys.
// Depends on hbkd_pkg.
module hbkd_diff #(
    parameter int KEY_SLOTS = 6
) (
    input  hbkd_pkg::t_byte        i_prev [KEY_SLOTS],
    input  hbkd_pkg::t_byte        i_cur  [KEY_SLOTS],
    output logic [2*KEY_SLOTS-1:0] o_mask
);
    import hbkd_pkg::*;

    logic [KEY_SLOTS-1:0] prev_live;
    logic [KEY_SLOTS-1:0] cur_live;

    always_comb begin
        prev_live[0] = (i_prev[0] != 8'h00);
        cur_live[0]  = (i_cur[0]  != 8'h00);
        for (int i = 1; i < KEY_SLOTS; i++) begin
            prev_live[i] = prev_live[i-1] && (i_prev[i] != 8'h00);
            cur_live[i]  = cur_live[i-1]  && (i_cur[i]  != 8'h00);
        end
    end

    always_comb begin
        logic in_cur;
        logic in_prev;
        o_mask = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            in_cur  = 1'b0;
            in_prev = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (cur_live[j] && i_cur[j] == i_prev[i]) begin
                    in_cur = 1'b1;
                end
                if (prev_live[j] && i_prev[j] == i_cur[i]) begin
                    in_prev = 1'b1;
                end
            end
            o_mask[i]           = prev_live[i] && !in_cur;
            o_mask[KEY_SLOTS+i] = cur_live[i]  && !in_prev;
        end
    end

endmodule

>>> rtl/hbkd_emit.sv
// Event emitter: holds pending events of one report and drains them in order
// through the output register. Depends on hbkd_pkg.
module hbkd_emit #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  hbkd_pkg::t_byte        i_keys [2*KEY_SLOTS],
    input  logic [2*KEY_SLOTS-1:0] i_mask,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  logic                   i_stall,
    output hbkd_pkg::t_byte        o_usage_code,
    output hbkd_pkg::t_byte        o_device_scancode,
    output hbkd_pkg::t_byte        o_ascii_code,
    output logic                   o_is_release,
    output logic                   o_last_event
);
    import hbkd_pkg::*;

    localparam int EVENTS = 2 * KEY_SLOTS;
    localparam int IW     = $clog2(EVENTS);

    t_byte             r_keys [EVENTS];
    logic [EVENTS-1:0] r_mask;
    logic [EVENTS-1:0] n_mask;
    logic [EVENTS-1:0] rest;
    logic [IW-1:0]     sel;
    logic              advance;
    t_byte             key;

    logic  r_out_valid;
    t_byte r_usage;
    t_byte r_scan;
    t_byte r_ascii;
    logic  r_rel;
    logic  r_last;

    always_comb begin
        sel = '0;
        for (int i = EVENTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = IW'(i);
            end
        end
    end

    assign key        = r_keys[sel];
    assign rest       = r_mask & (r_mask - 1'b1);
    assign advance    = (r_mask != '0) && (!r_out_valid || !i_stall);
    assign o_can_load = (r_mask == '0) || (advance && rest == '0);

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_mask;
        end else if (advance) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_keys <= i_keys;
        end
        if (advance) begin
            r_usage <= key;
            r_scan  <= f_scan(key);
            r_ascii <= f_ascii(key);
            r_rel   <= (32'(sel) < KEY_SLOTS);
            r_last  <= (rest == '0);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_usage_code      = r_usage;
    assign o_device_scancode = r_scan;
    assign o_ascii_code      = r_ascii;
    assign o_is_release      = r_rel;
    assign o_last_event      = r_last;

endmodule

>>> rtl/hid_boot_key_report_diff_top.sv
// HID boot-keyboard report differ, top level. Depends on hbkd_pkg, hbkd_diff, hbkd_emit.
// The first event of a report reaches the output register after the report is loaded into
// the pending set. Throughput: one event per cycle while i_stall does not hold the output;
// a report yields up to 2*KEY_SLOTS events, and a report is taken in the cycle its predecessor's
// last event leaves the pending set. A report with no changes yields no event.
// Reset: synchronous, active low; clears the stored key list, pending events and output valid.
module hid_boot_key_report_diff_top #(
    parameter int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hbkd_pkg::t_byte i_key_slot0,
    input  hbkd_pkg::t_byte i_key_slot1,
    input  hbkd_pkg::t_byte i_key_slot2,
    input  hbkd_pkg::t_byte i_key_slot3,
    input  hbkd_pkg::t_byte i_key_slot4,
    input  hbkd_pkg::t_byte i_key_slot5,
    output logic            o_valid,
    input  logic            i_stall,
    output hbkd_pkg::t_byte o_usage_code,
    output hbkd_pkg::t_byte o_device_scancode,
    output hbkd_pkg::t_byte o_ascii_code,
    output logic            o_is_release,
    output logic            o_last_event
);
    import hbkd_pkg::*;

    t_byte             in_slots [INPUT_FIELDS];
    t_byte             cur      [KEY_SLOTS];
    t_byte             r_prev   [KEY_SLOTS];
    t_byte             keys     [2*KEY_SLOTS];
    logic [2*KEY_SLOTS-1:0] mask;
    logic              can_load;
    logic              accept;

    assign in_slots[0] = i_key_slot0;
    assign in_slots[1] = i_key_slot1;
    assign in_slots[2] = i_key_slot2;
    assign in_slots[3] = i_key_slot3;
    assign in_slots[4] = i_key_slot4;
    assign in_slots[5] = i_key_slot5;

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            cur[i] = (i < INPUT_FIELDS) ? in_slots[i] : 8'h00;
            keys[i]           = r_prev[i];
            keys[KEY_SLOTS+i] = cur[i];
        end
    end

    assign o_stall = !can_load;
    assign accept  = i_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev[i] <= 8'h00;
            end
        end else if (accept) begin
            r_prev <= cur;
        end
    end

    hbkd_diff #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_diff (
        .i_prev(r_prev),
        .i_cur (cur),
        .o_mask(mask)
    );

    hbkd_emit #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (accept),
        .i_keys           (keys),
        .i_mask           (mask),
        .o_can_load       (can_load),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_usage_code     (o_usage_code),
        .o_device_scancode(o_device_scancode),
        .o_ascii_code     (o_ascii_code),
        .o_is_release     (o_is_release),
        .o_last_event     (o_last_event)
    );

endmodule

>>> sim/hid_boot_key_report_diff_top_tb.sv
// Testbench for hid_boot_key_report_diff_top: sends boot-keyboard reports and checks
// each key event against a scoreboard fed by a local model of the report differ.
// Depends on hbkd_pkg and the RTL of the top level only.
`timescale 1ns / 100ps

module hid_boot_key_report_diff_top_tb;

    import hbkd_pkg::*;

    localparam int NUM_SLOTS   = 6;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 30;
    localparam int REPORT_SHOW = 10;

    typedef t_byte t_report [NUM_SLOTS];

    typedef struct packed {
        t_byte usage;
        t_byte scancode;
        t_byte ascii;
        logic  release_flag;
        logic  last_flag;
    } t_key_event;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_byte i_key_slot0 = '0;
    t_byte i_key_slot1 = '0;
    t_byte i_key_slot2 = '0;
    t_byte i_key_slot3 = '0;
    t_byte i_key_slot4 = '0;
    t_byte i_key_slot5 = '0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_byte o_usage_code;
    t_byte o_device_scancode;
    t_byte o_ascii_code;
    logic  o_is_release;
    logic  o_last_event;

    hid_boot_key_report_diff_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_key_slot0       (i_key_slot0),
        .i_key_slot1       (i_key_slot1),
        .i_key_slot2       (i_key_slot2),
        .i_key_slot3       (i_key_slot3),
        .i_key_slot4       (i_key_slot4),
        .i_key_slot5       (i_key_slot5),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_usage_code      (o_usage_code),
        .o_device_scancode (o_device_scancode),
        .o_ascii_code      (o_ascii_code),
        .o_is_release      (o_is_release),
        .o_last_event      (o_last_event)
    );

    t_byte      held_keys [NUM_SLOTS];
    t_key_event pending_events [$];
    t_byte      typed_keys [$];
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         reports_sent = 0;
    int         events_seen = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_byte scan_of(t_byte u);
        t_byte idx;
        t_byte col_base;
        idx = u - 8'h04;
        case (idx[1:0])
            2'd0: col_base = 8'h66;
            2'd1: col_base = 8'h46;
            2'd2: col_base = 8'h26;
            default: col_base = 8'h85;
        endcase
        if (u < 8'h04 || u > 8'h1D) begin
            return 8'h00;
        end
        return col_base - (idx >> 2);
    endfunction

    function automatic t_byte ascii_of(t_byte u);
        if (u < 8'h04 || u > 8'h1D) begin
            return 8'h00;
        end
        return 8'h61 + (u - 8'h04);
    endfunction

    function automatic bit key_listed(t_report list, t_byte key);
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (list[j] == 8'h00) begin
                return 1'b0;
            end
            if (list[j] == key) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_key_event make_event(t_byte key, logic rel);
        t_key_event ev;
        ev.usage        = key;
        ev.scancode     = scan_of(key);
        ev.ascii        = ascii_of(key);
        ev.release_flag = rel;
        ev.last_flag    = 1'b0;
        return ev;
    endfunction

    task automatic diff_report(input t_report cur);
        t_key_event found [$];
        for (int i = 0; i < NUM_SLOTS && held_keys[i] != 8'h00; i++) begin
            if (!key_listed(cur, held_keys[i])) begin
                found.push_back(make_event(held_keys[i], 1'b1));
            end
        end
        for (int i = 0; i < NUM_SLOTS && cur[i] != 8'h00; i++) begin
            if (!key_listed(held_keys, cur[i])) begin
                found.push_back(make_event(cur[i], 1'b0));
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last_flag = 1'b1;
        end
        foreach (found[k]) begin
            pending_events.push_back(found[k]);
        end
        held_keys = cur;
        reports_sent++;
    endtask

    task automatic note_mismatch(input string what, input t_key_event exp_ev,
                                 input t_key_event got_ev);
        mismatches++;
        if (mismatches <= REPORT_SHOW) begin
            $display("%0t mismatch (%s): exp usage %h scan %h ascii %h rel %b last %b",
                     $realtime, what, exp_ev.usage, exp_ev.scancode, exp_ev.ascii,
                     exp_ev.release_flag, exp_ev.last_flag);
            $display("%0t               got usage %h scan %h ascii %h rel %b last %b",
                     $realtime, got_ev.usage, got_ev.scancode, got_ev.ascii,
                     got_ev.release_flag, got_ev.last_flag);
        end
    endtask

    // Called at a rising edge; returns at the edge where the transaction was taken.
    task automatic send_report(input t_report rep);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key_slot0 <= rep[0];
        i_key_slot1 <= rep[1];
        i_key_slot2 <= rep[2];
        i_key_slot3 <= rep[3];
        i_key_slot4 <= rep[4];
        i_key_slot5 <= rep[5];
        @(negedge i_clk);
        while (o_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        diff_report(rep);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        idle_pct  = sender_pct;
        stall_pct = receiver_pct;
    endtask

    task automatic test_extremes;
        send_report('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_report('{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
        send_report('{8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA});
        send_report('{8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h03, 8'h01});
        send_report('{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA});
        send_report('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    task automatic test_no_change;
        send_report('{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15});
        send_report('{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15});
        send_report('{8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h10});
    endtask

    task automatic test_after_zero;
        send_report('{8'h04, 8'h05, 8'h00, 8'hFF, 8'hFE, 8'hFD});
        send_report('{8'h04, 8'h05, 8'h00, 8'h11, 8'h22, 8'h33});
        send_report('{8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
    endtask

    task automatic test_repeated_usage;
        send_report('{8'h2A, 8'h2A, 8'h2A, 8'h00, 8'h00, 8'h00});
        send_report('{8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_report('{8'h0B, 8'h0B, 8'h2A, 8'h0B, 8'h0C, 8'h0C});
        send_report('{8'h00, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A});
    endtask

    task automatic test_unmapped;
        send_report('{8'h01, 8'h02, 8'h03, 8'h1E, 8'h1F, 8'h20});
        send_report('{8'h21, 8'h39, 8'hE0, 8'hE7, 8'h00, 8'h00});
        send_report('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    // Keep a set of held keys and walk it with presses, releases and clears; bytes past its zero end are noise.
    task automatic test_typing(input int count);
        t_report rep;
        t_byte   key;
        int      pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45 && typed_keys.size() < NUM_SLOTS) begin
                key = ($urandom_range(4) != 0) ? t_byte'($urandom_range(8'h38, 8'h04))
                                               : t_byte'($urandom_range(255, 1));
                if (!(key inside {typed_keys})) begin
                    typed_keys.insert($urandom_range(typed_keys.size()), key);
                end
            end else if (pick < 85 && typed_keys.size() > 0) begin
                typed_keys.delete($urandom_range(typed_keys.size() - 1));
            end else if (pick >= 95) begin
                typed_keys.delete();
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (i < typed_keys.size()) begin
                    rep[i] = typed_keys[i];
                end else if (i > typed_keys.size() && $urandom_range(3) == 0) begin
                    rep[i] = t_byte'($urandom_range(255));
                end else begin
                    rep[i] = 8'h00;
                end
            end
            send_report(rep);
        end
    endtask

    task automatic test_noise(input int count);
        t_report rep;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if ($urandom_range(99) < 12) begin
                    rep[i] = 8'h00;
                end else if (i > 0 && $urandom_range(99) < 10) begin
                    rep[i] = rep[i - 1];
                end else begin
                    rep[i] = t_byte'($urandom_range(255));
                end
            end
            send_report(rep);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(negedge i_clk) begin
        t_key_event got_ev;
        t_key_event exp_ev;
        if (i_rst_n && o_valid && !i_stall) begin
            got_ev = '{o_usage_code, o_device_scancode, o_ascii_code,
                       o_is_release, o_last_event};
            events_seen++;
            if (pending_events.size() == 0) begin
                note_mismatch("unexpected event", '0, got_ev);
            end else begin
                exp_ev = pending_events.pop_front();
                if (got_ev !== exp_ev) begin
                    note_mismatch("wrong event", exp_ev, got_ev);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        foreach (held_keys[i]) begin
            held_keys[i] = 8'h00;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_extremes();
        test_no_change();
        test_after_zero();
        test_repeated_usage();
        test_unmapped();

        set_idling(0, 0);
        test_typing(100);
        test_noise(25);
        set_idling(60, 0);
        test_typing(100);
        test_noise(25);
        set_idling(0, 60);
        test_typing(100);
        test_noise(25);
        set_idling(21, 21);
        test_typing(100);
        test_noise(25);
        i_valid <= 1'b0;

        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d reports and %0d key events over four idle/stall phases,",
                 reports_sent, events_seen);
        $display("with %0d mismatches and %0d events still outstanding.",
                 mismatches, pending_events.size());
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
